@@ sv/rstc_pkg.sv @@
// shared types, constants and codes for the rtp sequence tracker and concealer
package rstc_pkg;

  localparam int HDR_BYTES              = 12;
  localparam int DEF_MAX_PACKET_BYTES   = 2048;
  localparam int DEF_CONCEAL_MAX_BYTES  = 1024;
  localparam int DEF_MAX_CONCEAL        = 3;

  localparam int SEQ_W   = 16;
  localparam int LEN_W   = 12;
  localparam int BYTES_W = 11;
  localparam int SLOT_W  = 3;
  localparam int GAP_W   = 4;
  localparam int CNT_W   = 32;
  localparam int KIND_W  = 3;
  localparam int PT_W    = 7;
  localparam int LIM_W   = 2;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 144;

  localparam logic [1:0]      RTP_VERSION = 2'd2;
  localparam logic [PT_W-1:0] PT_RESET    = 7'd96;
  localparam logic [LIM_W-1:0] LIM_RESET  = 2'd3;
  localparam logic [BYTES_W-1:0] PAYLOAD_MAX = 11'h7FF;

  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CONCEAL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INVALID = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LATE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BUSY    = 3'd4;

  localparam logic REG_PT            = 1'b0;
  localparam logic REG_CONCEAL_LIMIT = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]  final_kind;
    logic [GAP_W-1:0]   n_conceal;
    logic [BYTES_W-1:0] fill_len;
    logic [BYTES_W-1:0] data_len;
    logic [SLOT_W-1:0]  slots;
  } plan_t;

  typedef struct packed {
    logic               seq_valid;
    logic [SEQ_W-1:0]   prev_seq;
    logic [BYTES_W-1:0] prev_len;
  } seq_state_t;

  typedef struct packed {
    logic [7:0]        first_byte;
    logic [7:0]        second_byte;
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  length;
    logic              idle;
    logic [SLOT_W-1:0] slots;
  } pkt_t;

endpackage

@@ sv/rstc_apb_regs.sv @@
// configuration registers behind the apb port
module rstc_apb_regs
  import rstc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [PT_W-1:0]   exp_pt,
  output logic [LIM_W-1:0]  conceal_limit
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_pt        <= PT_RESET;
      conceal_limit <= LIM_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_PT:            exp_pt        <= pwdata[PT_W-1:0];
        REG_CONCEAL_LIMIT: conceal_limit <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PT:            prdata = {{(DATA_W-PT_W){1'b0}}, exp_pt};
      REG_CONCEAL_LIMIT: prdata = {{(DATA_W-LIM_W){1'b0}}, conceal_limit};
      default:           prdata = '0;
    endcase
  end

endmodule

@@ sv/rstc_classify.sv @@
// header checks, sequence compare and the result plan for one packet
module rstc_classify
  import rstc_pkg::*;
#(
  parameter int MAX_PACKET_BYTES  = DEF_MAX_PACKET_BYTES,
  parameter int CONCEAL_MAX_BYTES = DEF_CONCEAL_MAX_BYTES,
  parameter int MAX_CONCEAL       = DEF_MAX_CONCEAL
) (
  input  pkt_t              pkt,
  input  logic [PT_W-1:0]   exp_pt,
  input  logic [LIM_W-1:0]  conceal_limit,
  input  seq_state_t        st,
  output plan_t             plan,
  output logic              st_we,
  output seq_state_t        st_next
);

  logic [16:0]        len_ext;
  logic [16:0]        len_c;
  logic [16:0]        payload_w;
  logic [BYTES_W-1:0] payload;
  logic [GAP_W-1:0]   lim;
  logic [SEQ_W-1:0]   diff;
  logic               bad, late, gap, in_limit, conceal, resync, acc_pay;
  logic [BYTES_W-1:0] cb_raw;
  logic [GAP_W-1:0]   n;

  always_comb begin
    len_ext = {{(17-LEN_W){1'b0}}, pkt.length};
    // receive buffer truncates oversized datagrams
    len_c = (len_ext > 17'(MAX_PACKET_BYTES)) ? 17'(MAX_PACKET_BYTES) : len_ext;
    bad = (len_c <= 17'(HDR_BYTES)) || (pkt.first_byte[7:6] != RTP_VERSION) ||
          (pkt.second_byte[PT_W-1:0] != exp_pt);
    payload_w = len_c - 17'(HDR_BYTES);
    payload = (payload_w > 17'(PAYLOAD_MAX)) ? PAYLOAD_MAX : payload_w[BYTES_W-1:0];

    lim = ({{(GAP_W-LIM_W){1'b0}}, conceal_limit} > GAP_W'(MAX_CONCEAL)) ?
          GAP_W'(MAX_CONCEAL) : {{(GAP_W-LIM_W){1'b0}}, conceal_limit};

    diff     = pkt.seq - (st.prev_seq + 16'd1);
    late     = st.seq_valid && diff[SEQ_W-1];
    gap      = st.seq_valid && !diff[SEQ_W-1] && (diff != '0);
    in_limit = diff <= {{(SEQ_W-GAP_W){1'b0}}, lim};
    conceal  = gap && in_limit;
    resync   = gap && !in_limit;
    n = conceal ? diff[GAP_W-1:0] : '0;

    // fall back to this payload size when no earlier payload is known
    cb_raw = (st.prev_len != '0) ? st.prev_len : payload;

    acc_pay = n < {{(GAP_W-SLOT_W){1'b0}}, pkt.slots};

    plan.n_conceal = '0;
    plan.fill_len  = ({1'b0, cb_raw} > 12'(CONCEAL_MAX_BYTES)) ?
                     BYTES_W'(CONCEAL_MAX_BYTES) : cb_raw;
    plan.data_len  = payload;
    plan.slots     = pkt.slots;
    st_we   = 1'b0;
    st_next = st;

    if (bad) begin
      plan.final_kind = KIND_INVALID;
    end else if (!pkt.idle) begin
      plan.final_kind = KIND_BUSY;
    end else if (late) begin
      plan.final_kind = KIND_LATE;
    end else begin
      plan.final_kind = KIND_PAYLOAD;
      plan.n_conceal  = n;
      if (acc_pay) begin
        st_we = 1'b1;
        st_next.seq_valid = 1'b1;
        st_next.prev_seq  = pkt.seq;
        st_next.prev_len  = payload;
      end else if (resync) begin
        st_we = 1'b1;
        st_next.seq_valid = 1'b0;
      end
    end
  end

endmodule

@@ sv/rstc_emitter.sv @@
// steps through a packet plan one result per cycle unless out_ready stalls it, keeps the statistics counters
module rstc_emitter
  import rstc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  plan_t              plan_in,
  output logic               plan_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  kind,
  output logic [BYTES_W-1:0] byte_count,
  output logic               delivered,
  output logic               last,
  output logic [CNT_W-1:0]   received_total,
  output logic [CNT_W-1:0]   concealed_total,
  output logic [CNT_W-1:0]   dropped_total,
  output logic [CNT_W-1:0]   reordered_total
);

  logic               plan_valid;
  plan_t              plan;
  logic [GAP_W-1:0]   left;
  logic [SLOT_W-1:0]  used;
  logic [CNT_W-1:0]   rx_cnt, cc_cnt, dr_cnt, lt_cnt;
  logic [CNT_W-1:0]   rx_next, cc_next, dr_next, lt_next;

  logic               emit, final_now, acc;
  logic [KIND_W-1:0]  r_kind;
  logic [BYTES_W-1:0] r_bytes;
  logic               r_acc;

  always_comb begin
    emit      = plan_valid && (!out_valid || out_ready);
    final_now = (left == '0);
    plan_free = !plan_valid || (emit && final_now);
    acc       = used < plan.slots;

    if (!final_now) begin
      r_kind  = KIND_CONCEAL;
      r_bytes = plan.fill_len;
      r_acc   = acc;
    end else if (plan.final_kind == KIND_PAYLOAD) begin
      r_kind  = KIND_PAYLOAD;
      r_bytes = plan.data_len;
      r_acc   = acc;
    end else begin
      r_kind  = plan.final_kind;
      r_bytes = '0;
      r_acc   = 1'b0;
    end

    rx_next = rx_cnt;
    cc_next = cc_cnt;
    dr_next = dr_cnt;
    lt_next = lt_cnt;
    if (emit) begin
      case (r_kind)
        KIND_PAYLOAD: begin
          if (r_acc) rx_next = rx_cnt + 32'd1;
          else       dr_next = dr_cnt + 32'd1;
        end
        KIND_CONCEAL: begin
          if (r_acc) cc_next = cc_cnt + 32'd1;
          else       dr_next = dr_cnt + 32'd1;
        end
        KIND_LATE: lt_next = lt_cnt + 32'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plan_valid <= 1'b0;
      out_valid  <= 1'b0;
      rx_cnt     <= '0;
      cc_cnt     <= '0;
      dr_cnt     <= '0;
      lt_cnt     <= '0;
      left       <= '0;
      used       <= '0;
    end else begin
      rx_cnt <= rx_next;
      cc_cnt <= cc_next;
      dr_cnt <= dr_next;
      lt_cnt <= lt_next;

      if (load) begin
        plan_valid <= 1'b1;
        left       <= plan_in.n_conceal;
        used       <= '0;
      end else if (emit) begin
        if (final_now) begin
          plan_valid <= 1'b0;
        end else begin
          left <= left - 4'd1;
          if (acc) used <= used + 3'd1;
        end
      end

      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) plan <= plan_in;
    if (emit) begin
      kind            <= r_kind;
      byte_count      <= r_bytes;
      delivered       <= r_acc;
      last            <= final_now;
      received_total  <= rx_next;
      concealed_total <= cc_next;
      dropped_total   <= dr_next;
      reordered_total <= lt_next;
    end
  end

endmodule

@@ sv/rtp_sequence_tracker_concealer_core.sv @@
// rtp receiver sequence tracker with loss concealment, top level
//
//  port group     dir  tdata / tuser content
//  s_axis_*       in   header_first_byte, header_second_byte, sequence_number,
//                      packet_length, session_idle, sink_slots
//  m_axis_*       out  byte_count, delivered, four totals; tuser kind; tlast last
//  apb            in   payload type at 0x0, conceal limit at 0x4
//
//  a packet gives n+1 result items, n the concealment count (at most MAX_CONCEAL),
//  one result item per cycle from the emitter while m_axis_tready does not hold it;
//  a packet holds the emitter until its final item, 4 items at most with the default limit
//  from input accept to result valid: input register, plan load, then output register
//  reset clears sequence state, counters and valids, and loads register defaults
//  m_axis_tready low holds the output register; the next packet still waits in the input
//  register and is taken as soon as the emitter finishes the current plan
module rtp_sequence_tracker_concealer_core
  import rstc_pkg::*;
#(
  parameter int MAX_PACKET_BYTES  = DEF_MAX_PACKET_BYTES,
  parameter int CONCEAL_MAX_BYTES = DEF_CONCEAL_MAX_BYTES,
  parameter int MAX_CONCEAL       = DEF_MAX_CONCEAL
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [7:0] header_first_byte, [15:8] header_second_byte, [31:16] sequence_number,
  // [43:32] packet_length, [44] session_idle, [47:45] sink_slots
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [10:0] byte_count, [11] delivered, [43:12] received_total,
  // [75:44] concealed_total, [107:76] dropped_total, [139:108] reordered_total
  output logic [OUT_W-1:0]  m_axis_tdata,
  // [2:0] kind
  output logic [KIND_W-1:0] m_axis_tuser,
  output logic              m_axis_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [PT_W-1:0]    exp_pt;
  logic [LIM_W-1:0]   conceal_limit;
  logic               in_valid;
  pkt_t               pkt;
  seq_state_t         st, st_next;
  logic               st_we;
  plan_t              plan;
  logic               plan_free, plan_take;
  logic [BYTES_W-1:0] byte_count;
  logic               delivered;
  logic [CNT_W-1:0]   received_total, concealed_total, dropped_total, reordered_total;

  rstc_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .exp_pt        (exp_pt),
    .conceal_limit (conceal_limit)
  );

  assign plan_take     = in_valid && plan_free;
  assign s_axis_tready = !in_valid || plan_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      st       <= '0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (plan_take && st_we) st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) pkt <= pkt_t'({s_axis_tdata[7:0],
        s_axis_tdata[15:8], s_axis_tdata[31:16], s_axis_tdata[43:32],
        s_axis_tdata[44], s_axis_tdata[47:45]});
  end

  rstc_classify #(
    .MAX_PACKET_BYTES  (MAX_PACKET_BYTES),
    .CONCEAL_MAX_BYTES (CONCEAL_MAX_BYTES),
    .MAX_CONCEAL       (MAX_CONCEAL)
  ) u_classify (
    .pkt           (pkt),
    .exp_pt        (exp_pt),
    .conceal_limit (conceal_limit),
    .st            (st),
    .plan          (plan),
    .st_we         (st_we),
    .st_next       (st_next)
  );

  rstc_emitter u_emitter (
    .clk             (clk),
    .rst             (rst),
    .load            (plan_take),
    .plan_in         (plan),
    .plan_free       (plan_free),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .kind            (m_axis_tuser),
    .byte_count      (byte_count),
    .delivered       (delivered),
    .last            (m_axis_tlast),
    .received_total  (received_total),
    .concealed_total (concealed_total),
    .dropped_total   (dropped_total),
    .reordered_total (reordered_total)
  );

  assign m_axis_tdata = {4'b0, reordered_total, dropped_total, concealed_total,
                         received_total, delivered, byte_count};

  // only concealment frames come before the final result of a packet
  a_nonlast_conceal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == KIND_CONCEAL)
    else $error("non-final result is not a concealment frame");

  // discards carry no audio and are never delivered
  a_discard_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_INVALID || m_axis_tuser == KIND_LATE ||
    m_axis_tuser == KIND_BUSY) |-> byte_count == '0 && !delivered)
    else $error("discard result carries bytes or delivery");

  // the rest of a packet follows without a bubble
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside the results of one packet");

  // a new plan is taken only when the emitter is done with the last one
  a_take_free: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready && in_valid |-> plan_free)
    else $error("input register released while emitter busy");

endmodule
